[rtl/nmea_rmc_field_splitter_core_assert.svh]
// Assertion macros used by the checker file (nmrmc_chk) of the NMEA RMC field splitter.
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low; the using scope must see clk and rst_n.
`ifndef NMEA_RMC_FIELD_SPLITTER_CORE_ASSERT_SVH
`define NMEA_RMC_FIELD_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define NMRMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NMRMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nmrmc_pkg.sv]
// Package for the NMEA RMC field splitter: request codes, character constants,
// header text lookup and the result record. No dependencies.
`timescale 1ns / 1ps

package nmrmc_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_ARM  = 2'd1;
  localparam logic [1:0] MODE_ACK  = 2'd2;

  localparam int CMD_LEN_DEF   = 16;
  localparam int FIELD_LEN_DEF = 16;

  localparam int TOK_W = 5;   // token offset, saturates at all ones
  localparam int LIM_W = 6;   // wide enough to hold a limit of 32
  localparam int FLD_W = 4;

  localparam logic [TOK_W-1:0] TOK_MAX    = '1;
  localparam logic [TOK_W-1:0] HDR_LEN    = 5'd6;
  localparam logic [FLD_W-1:0] NUM_FIELDS = 4'd9;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // "$GPRMC", one character per slot
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h50;  // P
      3'd3:    c = 8'h52;  // R
      3'd4:    c = 8'h4D;  // M
      3'd5:    c = 8'h43;  // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic             write_enable;
    logic [FLD_W-1:0] field_index;
    logic [3:0]       char_offset;
    logic [7:0]       char_value;
    logic             sentence_done;
    logic             ready_res;
    logic             armed;
  } res_t;

endpackage

[rtl/nmrmc_parse.sv]
// Tokenizer and capture state of the NMEA RMC field splitter: holds the
// running state and forms one result per request. Depends on nmrmc_pkg.
`timescale 1ns / 1ps

module nmrmc_parse #(
  parameter int CMD_LEN   = nmrmc_pkg::CMD_LEN_DEF,
  parameter int FIELD_LEN = nmrmc_pkg::FIELD_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [1:0]        mode,
  input  logic [7:0]        rx_byte,
  output nmrmc_pkg::res_t   res
);
  import nmrmc_pkg::*;

  localparam logic [LIM_W-1:0] CMD_LIM   = LIM_W'(CMD_LEN);
  localparam logic [LIM_W-1:0] FIELD_LIM = LIM_W'(FIELD_LEN);

  logic             armed_r, armed_nxt;
  logic             found_r, found_nxt;
  logic [FLD_W-1:0] cnt_r, cnt_nxt;
  logic [TOK_W-1:0] off_r, off_nxt;
  logic             match_r, match_nxt;
  logic             ready_r, ready_nxt;

  always_comb begin
    logic [LIM_W-1:0] lim;
    logic             term;
    logic             found;
    logic [FLD_W-1:0] cnt;
    armed_nxt = armed_r;
    found_nxt = found_r;
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    match_nxt = match_r;
    ready_nxt = ready_r;
    res       = '0;
    lim       = found_r ? FIELD_LIM : CMD_LIM;
    term      = ({1'b0, off_r} + LIM_W'(1) >= lim) || rx_byte == CH_COMMA ||
                rx_byte == CH_LF || rx_byte == CH_CR;
    found     = found_r;
    cnt       = cnt_r;
    case (mode)
      MODE_ARM: begin
        if (!armed_r) begin
          armed_nxt = 1'b1;
          found_nxt = 1'b0;
          off_nxt   = '0;
          match_nxt = 1'b1;
        end
      end
      MODE_ACK: begin
        ready_nxt = 1'b0;
      end
      MODE_BYTE: begin
        if (armed_r) begin
          if (found_r) begin
            res.write_enable = 1'b1;
            res.field_index  = cnt_r - FLD_W'(1);
            res.char_offset  = off_r[3:0];
            res.char_value   = term ? 8'h00 : rx_byte;
          end
          if (!term) begin
            if (off_r >= HDR_LEN || hdr_char(off_r[2:0]) != rx_byte) begin
              match_nxt = 1'b0;
            end
            if (off_r != TOK_MAX) begin
              off_nxt = off_r + TOK_W'(1);
            end
          end else begin
            // A header token restarts capture, even inside a sentence
            if (match_r && off_r == HDR_LEN) begin
              found = 1'b1;
              cnt   = '0;
            end
            if (found) begin
              if (cnt < NUM_FIELDS) begin
                cnt_nxt = cnt + FLD_W'(1);
              end else begin
                armed_nxt         = 1'b0;
                ready_nxt         = 1'b1;
                res.sentence_done = 1'b1;
              end
            end
            found_nxt = found;
            off_nxt   = '0;
            match_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.ready_res = ready_nxt;
    res.armed     = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      found_r <= 1'b0;
      cnt_r   <= '0;
      off_r   <= '0;
      match_r <= 1'b1;
      ready_r <= 1'b0;
    end else if (step_en) begin
      armed_r <= armed_nxt;
      found_r <= found_nxt;
      cnt_r   <= cnt_nxt;
      off_r   <= off_nxt;
      match_r <= match_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

[rtl/nmea_rmc_field_splitter_core.sv]
// NMEA RMC field splitter, top level. Every request on the input stream gives
// exactly one result on the output stream, and one request is taken per cycle
// sustained while the output is not stalled by out_tready: an input register
// feeds the tokenizer (nmrmc_parse), whose result lands in an output register,
// and the running state advances as the result is registered. tuser
// selects the request: 0 a received byte, 1 arm for the next sentence, 2
// acknowledge; 3 is ignored. While armed, bytes are split into tokens at comma,
// CR, LF or at the length limit (CMD_LEN while hunting for "$GPRMC", FIELD_LEN
// while capturing; the byte in the last slot ends the token). After the header,
// nine fields are written out character by character, each closed by a zero
// write; then the block disarms and holds ready until acknowledged.
// Depends on nmrmc_pkg and nmrmc_parse.
`timescale 1ns / 1ps

module nmea_rmc_field_splitter_core #(
  parameter int CMD_LEN   = nmrmc_pkg::CMD_LEN_DEF,    // 8 .. 32
  parameter int FIELD_LEN = nmrmc_pkg::FIELD_LEN_DEF   // 2 .. 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] field_index, [7:4] char_offset,
                                  // [15:8] char_value, [16] sentence_done,
                                  // [17] ready_res, [18] armed, [23:19] zero
  output logic        out_tuser   // [0] write_enable
);
  import nmrmc_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_mode_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;
  res_t       res;
  logic       adv;
  logic       in_acc;

  // Output register free this cycle: advance the input stage into it
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  nmrmc_parse #(
    .CMD_LEN   (CMD_LEN),
    .FIELD_LEN (FIELD_LEN)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_valid_r && adv),
    .mode    (s1_mode_r),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    if (s1_valid_r && adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
    if (s1_valid_r && adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.write_enable;
  assign out_tdata  = {5'd0, out_res_r.armed, out_res_r.ready_res,
                       out_res_r.sentence_done, out_res_r.char_value,
                       out_res_r.char_offset, out_res_r.field_index};

endmodule

[rtl/nmrmc_chk.sv]
// Port-level checker for the NMEA RMC field splitter, bound to the top level.
// Depends on nmea_rmc_field_splitter_core_assert.svh.
`timescale 1ns / 1ps
`include "nmea_rmc_field_splitter_core_assert.svh"

module nmrmc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // Stalled result holds
  `NMRMC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // No write: field, offset and character are zero
  `NMRMC_ASSERT_NOW(a_idle_zero, out_tvalid && !out_tuser, out_tdata[15:0] == 16'd0, "payload set without write")

  // Sentence end is a terminator write that disarms and raises ready
  `NMRMC_ASSERT_NOW(a_done, out_tvalid && out_tdata[16], out_tuser && out_tdata[17] && !out_tdata[18] && out_tdata[15:8] == 8'd0, "bad sentence end")

  // Writes other than the last terminator happen while armed, on a field 0..8
  `NMRMC_ASSERT_NOW(a_write_armed, out_tvalid && out_tuser && !out_tdata[16], out_tdata[18] && out_tdata[3:0] <= 4'd8 && out_tdata[23:19] == 5'd0, "write outside capture")

endmodule

bind nmea_rmc_field_splitter_core nmrmc_chk u_nmrmc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
